// ----- design/gedf_pkg.sv -----
// ----------------------------------------------------------------------------
// gedf_pkg
// Shared types and constants of the EDF tick dispatcher: item and result
// beats, controller command/status groups, result kinds and defaults.
// ----------------------------------------------------------------------------
package gedf_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int NUM_CORES_DEF   = 4;
    localparam int MAX_SLOTS       = 4;

    localparam int FIELD_W  = 16;
    localparam int ENTRY_W  = 3 * FIELD_W;   // id, deadline, burst
    localparam int CORES_W  = 3;

    localparam logic [CORES_W-1:0] ACTIVE_CORES_RST = 3'd4;

    // item command codes
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // result kind codes
    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_DROP   = 2'd1;
    localparam logic [1:0] KIND_SLOT   = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [FIELD_W-1:0] task_id;
        logic [FIELD_W-1:0] task_deadline;
        logic [FIELD_W-1:0] task_burst;
    } item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         core_slot;
        logic               slot_valid;
        logic [FIELD_W-1:0] run_id;
        logic [FIELD_W-1:0] run_deadline;
        logic               last;
    } result_t;

    typedef struct packed {
        logic capture;
        logic idx_clr;
        logic idx_inc;
        logic arr_commit;
        logic arr_drop;
        logic rd_issue;
        logic cand_take;
        logic upd_take;
        logic buf_clr;
        logic slot_clr;
        logic emit_slot;
    } ctl_cmd_t;

    typedef struct packed {
        logic free_hit;
        logic idx_last;
        logic slot_last;
    } ctl_sts_t;

endpackage

// ----- design/global_edf_tick_dispatcher.sv -----
// ----------------------------------------------------------------------------
// global_edf_tick_dispatcher
// Earliest-deadline-first task table serving up to four cores per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Present an item on item and raise start; the item is taken at the edge
//   where start is high and busy is low. An arrival (cmd 0) stores the task
//   in the lowest free table entry, or drops it when the table is full, and
//   answers with one status beat. A tick (cmd 1) answers with one dispatch
//   beat per core slot, earliest deadline first, ties to the smaller id.
//   Result beats appear on result for one cycle each, marked by strobe;
//   result.last flags the final beat of an item. The receiver cannot stall.
//   An arrival walks over the valid flags to the first free entry. A tick
//   makes one pass over the table RAM's read port to fill the sorted pick
//   buffer, then a second read/write-back pass to age deadlines and bursts,
//   with the slot beats emitted during it. One item is in flight at a time.
//   cfg_we/cfg_wdata write active_cores; write only while busy is low.
//   Reset empties the table (valid flags cleared) and sets active_cores to 4.
// ----------------------------------------------------------------------------
module global_edf_tick_dispatcher #(
    parameter int TABLE_DEPTH = gedf_pkg::TABLE_DEPTH_DEF,
    parameter int NUM_CORES   = gedf_pkg::NUM_CORES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  gedf_pkg::item_t              item,
    output logic                         strobe,
    output gedf_pkg::result_t            result,
    input  logic                         cfg_we,
    input  logic [gedf_pkg::CORES_W-1:0] cfg_wdata
);

    gedf_pkg::ctl_cmd_t cmd;
    gedf_pkg::ctl_sts_t sts;

    gedf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .tick  (item.cmd),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    gedf_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NUM_CORES   (NUM_CORES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .strobe    (strobe),
        .result    (result)
    );

    // a beat only follows a cycle of work
    a_beat_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result beat without pending work");

    // status beats are single and final
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.kind != gedf_pkg::KIND_SLOT) |-> result.last)
        else $error("status beat not marked last");

    // slot beats run back to back with rising slot numbers
    a_slot_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.kind == gedf_pkg::KIND_SLOT && !result.last) |=>
        (strobe && result.kind == gedf_pkg::KIND_SLOT &&
         result.core_slot == 2'($past(result.core_slot) + 2'd1)))
        else $error("slot beats out of sequence");

    // nothing trails the final beat of an item
    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !strobe)
        else $error("beat right after final beat");

endmodule

// ----- design/gedf_ram.sv -----
// ----------------------------------------------------------------------------
// gedf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gedf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/gedf_ctrl.sv -----
// ----------------------------------------------------------------------------
// gedf_ctrl
// Sequencer of the dispatcher: arrival search, selection scan, and the
// update pass with the slot beats emitted alongside it.
// ----------------------------------------------------------------------------
module gedf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               tick,
    output logic               busy,
    output gedf_pkg::ctl_cmd_t cmd,
    input  gedf_pkg::ctl_sts_t sts
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ARRIVE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_UPDATE = 6'b010000,
        S_FLUSH  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   emit_pend_reg;
    logic   emit_pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            emit_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_pend_reg <= emit_pend_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        emit_pend_next = emit_pend_reg;
        cmd            = '0;

        // slot beats run in parallel with the update pass
        if ((state_reg == S_UPDATE || state_reg == S_FLUSH) && emit_pend_reg)
        begin
            cmd.emit_slot = 1'b1;
            if (sts.slot_last)
            begin
                emit_pend_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    cmd.idx_clr = 1'b1;
                    if (tick == gedf_pkg::CMD_TICK)
                    begin
                        cmd.buf_clr  = 1'b1;
                        cmd.slot_clr = 1'b1;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_ARRIVE;
                    end
                end
            end
            S_ARRIVE:
            begin
                if (sts.free_hit)
                begin
                    cmd.arr_commit = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (sts.idx_last)
                begin
                    cmd.arr_drop = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.rd_issue  = 1'b1;
                cmd.cand_take = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_DRAIN:
            begin
                cmd.cand_take  = 1'b1;
                cmd.idx_clr    = 1'b1;
                emit_pend_next = 1'b1;
                state_next     = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.rd_issue = 1'b1;
                cmd.upd_take = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_FLUSH:
            begin
                cmd.upd_take = 1'b1;
                // hold until the last slot beat has gone out
                if (!emit_pend_reg || sts.slot_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- design/gedf_dpath.sv -----
// ----------------------------------------------------------------------------
// gedf_dpath
// Datapath of the dispatcher: task table RAM with valid flags, sorted
// pick buffer for the earliest tasks, update logic and result register.
// ----------------------------------------------------------------------------
module gedf_dpath #(
    parameter int TABLE_DEPTH = gedf_pkg::TABLE_DEPTH_DEF,
    parameter int NUM_CORES   = gedf_pkg::NUM_CORES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gedf_pkg::CORES_W-1:0]     cfg_wdata,
    input  gedf_pkg::item_t                  item,
    input  gedf_pkg::ctl_cmd_t               cmd,
    output gedf_pkg::ctl_sts_t               sts,
    output logic                             strobe,
    output gedf_pkg::result_t                result
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int SLOTS  = (NUM_CORES < gedf_pkg::MAX_SLOTS) ? NUM_CORES
                                                               : gedf_pkg::MAX_SLOTS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW     = gedf_pkg::FIELD_W;
    localparam int EW     = gedf_pkg::ENTRY_W;

    logic [gedf_pkg::CORES_W-1:0] ac_reg;
    logic [FW-1:0]                tid_reg;
    logic [FW-1:0]                tdl_reg;
    logic [FW-1:0]                tbu_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [IDX_W-1:0]             idx_next;
    logic [TABLE_DEPTH-1:0]       valid_reg;
    logic [TABLE_DEPTH-1:0]       valid_next;
    logic                         p1_vld_reg;
    logic [IDX_W-1:0]             p1_idx_reg;

    logic [SLOTS-1:0]             buf_vld_reg;
    logic [SLOTS-1:0]             buf_vld_next;
    logic [FW-1:0]                buf_id_reg   [SLOTS];
    logic [FW-1:0]                buf_id_next  [SLOTS];
    logic [FW-1:0]                buf_dl_reg   [SLOTS];
    logic [FW-1:0]                buf_dl_next  [SLOTS];
    logic [IDX_W-1:0]             buf_idx_reg  [SLOTS];
    logic [IDX_W-1:0]             buf_idx_next [SLOTS];
    logic [SLOT_W-1:0]            slot_reg;
    logic [SLOT_W-1:0]            slot_next;

    logic                         out_vld_reg;
    logic                         out_vld_next;
    gedf_pkg::result_t            out_reg;
    gedf_pkg::result_t            out_next;

    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [EW-1:0]                mem_wdata;
    logic [EW-1:0]                mem_rdata;
    logic [FW-1:0]                rd_id;
    logic [FW-1:0]                rd_dl;
    logic [FW-1:0]                rd_bu;
    logic                         rd_live;

    logic [SLOT_W-1:0]            cores_m1;
    logic [SLOTS-1:0]             less;
    logic [SLOTS-1:0]             less_prev;
    logic                         picked;

    gedf_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    assign rd_id   = mem_rdata[EW-1 -: FW];
    assign rd_dl   = mem_rdata[2*FW-1 -: FW];
    assign rd_bu   = mem_rdata[FW-1:0];
    assign rd_live = p1_vld_reg && valid_reg[p1_idx_reg];

    // effective core count minus one: zero counts as one, saturate at slots
    always_comb
    begin
        if (ac_reg == '0)
        begin
            cores_m1 = '0;
        end
        else if (32'(ac_reg) > SLOTS)
        begin
            cores_m1 = SLOT_W'(SLOTS - 1);
        end
        else
        begin
            cores_m1 = SLOT_W'(ac_reg - 3'd1);
        end
    end

    // insert the fresh entry into the sorted pick buffer; strict compare
    // keeps ascending entry order among equal keys
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            less[j] = !buf_vld_reg[j] || (rd_dl < buf_dl_reg[j]) ||
                      ((rd_dl == buf_dl_reg[j]) && (rd_id < buf_id_reg[j]));
        end
        less_prev = '0;
        for (int j = 1; j < SLOTS; j++)
        begin
            less_prev[j] = less[j-1];
        end

        buf_vld_next = buf_vld_reg;
        buf_id_next  = buf_id_reg;
        buf_dl_next  = buf_dl_reg;
        buf_idx_next = buf_idx_reg;

        if (cmd.buf_clr)
        begin
            buf_vld_next = '0;
        end
        else if (cmd.cand_take && rd_live)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                if (less[j])
                begin
                    if (!less_prev[j])
                    begin
                        buf_vld_next[j] = 1'b1;
                        buf_id_next[j]  = rd_id;
                        buf_dl_next[j]  = rd_dl;
                        buf_idx_next[j] = p1_idx_reg;
                    end
                    else
                    begin
                        // shift down behind the new entry
                        buf_vld_next[j] = buf_vld_reg[j-1];
                        buf_id_next[j]  = buf_id_reg[j-1];
                        buf_dl_next[j]  = buf_dl_reg[j-1];
                        buf_idx_next[j] = buf_idx_reg[j-1];
                    end
                end
            end
        end
    end

    always_comb
    begin
        picked = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (buf_vld_reg[j] && (buf_idx_reg[j] == p1_idx_reg) &&
                (SLOT_W'(j) <= cores_m1))
            begin
                picked = 1'b1;
            end
        end
    end

    // table writes, valid flags and result beats
    always_comb
    begin
        valid_next   = valid_reg;
        mem_we       = 1'b0;
        mem_waddr    = p1_idx_reg;
        mem_wdata    = {rd_id, rd_dl, rd_bu};
        out_vld_next = 1'b0;
        out_next     = '0;
        slot_next    = slot_reg;
        idx_next     = idx_reg;

        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        if (cmd.arr_commit)
        begin
            valid_next[idx_reg] = 1'b1;
            mem_we              = 1'b1;
            mem_waddr           = idx_reg;
            mem_wdata           = {tid_reg, tdl_reg, tbu_reg};
            out_vld_next        = 1'b1;
            out_next.kind       = gedf_pkg::KIND_ACCEPT;
            out_next.last       = 1'b1;
        end
        else if (cmd.arr_drop)
        begin
            out_vld_next  = 1'b1;
            out_next.kind = gedf_pkg::KIND_DROP;
            out_next.last = 1'b1;
        end

        if (cmd.upd_take && rd_live)
        begin
            if (picked && (rd_bu <= 16'd1))
            begin
                // burst used up: drop from the table
                valid_next[p1_idx_reg] = 1'b0;
            end
            else
            begin
                mem_we    = 1'b1;
                mem_wdata = {rd_id,
                             (rd_dl != '0) ? rd_dl - 16'd1 : rd_dl,
                             picked ? rd_bu - 16'd1 : rd_bu};
            end
        end

        if (cmd.slot_clr)
        begin
            slot_next = '0;
        end
        else if (cmd.emit_slot)
        begin
            slot_next               = slot_reg + SLOT_W'(1);
            out_vld_next            = 1'b1;
            out_next.kind           = gedf_pkg::KIND_SLOT;
            out_next.core_slot      = 2'(slot_reg);
            out_next.slot_valid     = buf_vld_reg[slot_reg];
            out_next.run_id         = buf_vld_reg[slot_reg] ? buf_id_reg[slot_reg] : '0;
            out_next.run_deadline   = buf_vld_reg[slot_reg] ? buf_dl_reg[slot_reg] : '0;
            out_next.last           = (slot_reg == cores_m1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac_reg      <= gedf_pkg::ACTIVE_CORES_RST;
            idx_reg     <= '0;
            valid_reg   <= '0;
            p1_vld_reg  <= 1'b0;
            buf_vld_reg <= '0;
            slot_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ac_reg <= cfg_wdata;
            end
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
            p1_vld_reg  <= cmd.rd_issue;
            buf_vld_reg <= buf_vld_next;
            slot_reg    <= slot_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tid_reg <= item.task_id;
            tdl_reg <= item.task_deadline;
            tbu_reg <= item.task_burst;
        end
        p1_idx_reg  <= idx_reg;
        buf_id_reg  <= buf_id_next;
        buf_dl_reg  <= buf_dl_next;
        buf_idx_reg <= buf_idx_next;
        out_reg     <= out_next;
    end

    assign sts.free_hit  = !valid_reg[idx_reg];
    assign sts.idx_last  = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign sts.slot_last = (slot_reg == cores_m1);

    assign strobe = out_vld_reg;
    assign result = out_reg;

endmodule
